/* hw/rtl/cmpi_pkg.sv */
package cmpi_pkg;

    localparam int FRAC_W     = 16;
    localparam int RES_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int COLOR_W    = 24;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_COUNT = 1'b0,
        CFG_RESOLUTION  = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_WRITE_ENTRY = 1'b0,
        OP_PALETTE     = 1'b1
    } t_op;

    typedef struct packed {
        logic        op;
        logic [7:0]  entry_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [15:0] palette_index;
    } t_in;

    typedef struct packed {
        logic [31:0] palette_word;
    } t_out;

    // Side data that travels with a word down the divider cells.
    typedef struct packed {
        logic               op;
        logic [7:0]         entry_index;
        logic [COLOR_W-1:0] color;
    } t_cell;

    // lo*(1-ratio) + up*ratio in Q0.16, truncated to eight bits.
    function automatic logic [7:0] mix_channel(input logic [7:0] lo, input logic [7:0] up,
                                               input logic [FRAC_W-1:0] ratio);
        logic [25:0] lo_w;
        logic [25:0] up_w;
        logic [25:0] inv_w;
        logic [25:0] rat_w;
        logic [25:0] acc;
        lo_w  = 26'(lo);
        up_w  = 26'(up);
        rat_w = 26'(ratio);
        inv_w = 26'(17'h10000) - rat_w;
        acc   = lo_w * inv_w + up_w * rat_w;
        return acc[23:16];
    endfunction

endpackage

/* hw/rtl/cmpi_stream_if.sv */
interface cmpi_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/cmpi_div_cell.sv */
module cmpi_div_cell #(
    parameter int QW = 41
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [cmpi_pkg::RES_W-1:0]     i_res,
    input  logic                           i_valid,
    input  cmpi_pkg::t_cell                i_tag,
    input  logic [cmpi_pkg::RES_W-1:0]     i_rem,
    input  logic [QW-1:0]                  i_work,
    output logic                           o_valid,
    output cmpi_pkg::t_cell                o_tag,
    output logic [cmpi_pkg::RES_W-1:0]     o_rem,
    output logic [QW-1:0]                  o_work
);

    logic                       r_valid;
    cmpi_pkg::t_cell            r_tag;
    logic [cmpi_pkg::RES_W-1:0] r_rem;
    logic [QW-1:0]              r_work;

    logic [cmpi_pkg::RES_W:0]   trial;
    logic [cmpi_pkg::RES_W:0]   diff;
    logic                       ge;
    logic [cmpi_pkg::RES_W-1:0] n_rem;
    logic [QW-1:0]              n_work;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb begin
        trial  = {i_rem, i_work[QW-1]};
        diff   = trial - {1'b0, i_res};
        ge     = (trial >= {1'b0, i_res});
        n_rem  = ge ? diff[cmpi_pkg::RES_W-1:0] : trial[cmpi_pkg::RES_W-1:0];
        n_work = {i_work[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag  <= i_tag;
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_rem   = r_rem;
    assign o_work  = r_work;

endmodule

/* hw/rtl/cmpi_lookup.sv */
module cmpi_lookup #(
    parameter int MAX_ENTRIES = 256,
    parameter int IDX_W       = 8,
    parameter int QW          = 41
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  cmpi_pkg::t_cell   i_tag,
    input  logic [QW-1:0]     i_quot,
    input  logic [IDX_W-1:0]  i_last,
    output logic              o_valid,
    output logic [31:0]       o_word
);

    localparam int POS_W = QW - cmpi_pkg::FRAC_W;

    logic [POS_W-1:0]                 lower;
    logic [POS_W-1:0]                 last_w;
    logic [cmpi_pkg::FRAC_W-1:0]      ratio;
    logic [IDX_W-1:0]                 n_lo;
    logic [IDX_W-1:0]                 n_up;

    logic                             r_c_valid;
    cmpi_pkg::t_cell                  r_c_tag;
    logic [IDX_W-1:0]                 r_c_lo;
    logic [IDX_W-1:0]                 r_c_up;
    logic [cmpi_pkg::FRAC_W-1:0]      r_c_ratio;

    logic [cmpi_pkg::COLOR_W-1:0]     r_mem [MAX_ENTRIES];
    logic                             wr_en;

    logic                             r_m_valid;
    logic [cmpi_pkg::FRAC_W-1:0]      r_m_ratio;
    logic [cmpi_pkg::COLOR_W-1:0]     r_m_lo;
    logic [cmpi_pkg::COLOR_W-1:0]     r_m_up;

    logic                             r_x_valid;
    logic [31:0]                      r_x_word;
    logic [31:0]                      n_word;

    // The quotient holds the entry position above the binary point and the ratio below.
    always_comb begin
        lower  = i_quot[QW-1:cmpi_pkg::FRAC_W];
        ratio  = i_quot[cmpi_pkg::FRAC_W-1:0];
        last_w = POS_W'(i_last);
        n_lo   = (lower > last_w) ? i_last : lower[IDX_W-1:0];
        // A non-zero ratio means a non-zero remainder, so the next entry is needed.
        n_up   = ((ratio != '0) && (lower < last_w)) ? (lower[IDX_W-1:0] + IDX_W'(1)) : n_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_x_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= i_valid;
            r_m_valid <= r_c_valid && (r_c_tag.op == cmpi_pkg::OP_PALETTE);
            r_x_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_tag   <= i_tag;
            r_c_lo    <= n_lo;
            r_c_up    <= n_up;
            r_c_ratio <= ratio;
            r_m_ratio <= r_c_ratio;
            r_x_word  <= n_word;
        end
    end

    // Entry writes reach the table at this stage, so they stay in order with requests.
    assign wr_en = i_en && r_c_valid && (r_c_tag.op == cmpi_pkg::OP_WRITE_ENTRY)
                   && (32'(r_c_tag.entry_index) < 32'(MAX_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[IDX_W'(r_c_tag.entry_index)] <= r_c_tag.color;
        end
        if (i_en) begin
            r_m_lo <= r_mem[r_c_lo];
            r_m_up <= r_mem[r_c_up];
        end
    end

    always_comb begin
        n_word = {cmpi_pkg::ALPHA_OPAQUE,
                  cmpi_pkg::mix_channel(r_m_lo[23:16], r_m_up[23:16], r_m_ratio),
                  cmpi_pkg::mix_channel(r_m_lo[15:8], r_m_up[15:8], r_m_ratio),
                  cmpi_pkg::mix_channel(r_m_lo[7:0], r_m_up[7:0], r_m_ratio)};
    end

    assign o_valid = r_x_valid;
    assign o_word  = r_x_word;

endmodule

/* hw/rtl/colormap_palette_interpolator.sv */
// A word passes the input register, QW divider cells, the lookup and the output register,
// where QW = 32 + clog2(MAX_ENTRIES + 1) is the number of divider cells (41 at the default).
// Throughput: one word per cycle unless stalled; each divider cell yields one quotient bit.
// Entry writes give no result and take effect in order with palette requests.
// Reset (synchronous, active low) empties the pipeline and sets entry_count to 1
// and resolution to 256; the colour table keeps no reset value.
module colormap_palette_interpolator #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cmpi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cmpi_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    cmpi_stream_if.sink                         i_in,
    cmpi_stream_if.source                       o_out
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W = 16 + CNT_W;
    localparam int QW    = POS_W + cmpi_pkg::FRAC_W;

    logic [CNT_W-1:0]           r_count;
    logic [IDX_W-1:0]           r_last;
    logic [cmpi_pkg::RES_W-1:0] r_res;
    logic [CNT_W-1:0]           n_count;
    logic [8:0]                 cfg_count;
    logic [cmpi_pkg::RES_W-1:0] cfg_res;

    logic                       adv;
    logic                       accept;
    cmpi_pkg::t_in              in_word;

    logic                       r_s0_valid;
    cmpi_pkg::t_cell            r_s0_tag;
    logic [POS_W-1:0]           r_s0_pos;

    logic                       c_valid [QW+1];
    cmpi_pkg::t_cell            c_tag   [QW+1];
    logic [cmpi_pkg::RES_W-1:0] c_rem   [QW+1];
    logic [QW-1:0]              c_work  [QW+1];

    logic                       lk_valid;
    logic [31:0]                lk_word;
    logic                       push;
    logic                       fire_out;

    logic                       r_out_valid;
    logic [31:0]                r_out_word;
    logic                       r_skid_valid;
    logic [31:0]                r_skid_word;

    // Configuration: the effective values are kept, so zero and oversize are settled here.
    always_comb begin
        cfg_count = i_cfg_data[8:0];
        cfg_res   = i_cfg_data[cmpi_pkg::RES_W-1:0];
        if (cfg_count == 9'd0) begin
            n_count = CNT_W'(1);
        end else if (32'(cfg_count) > 32'(MAX_ENTRIES)) begin
            n_count = CNT_W'(MAX_ENTRIES);
        end else begin
            n_count = CNT_W'(cfg_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(1);
            r_last  <= '0;
            r_res   <= cmpi_pkg::RES_W'(256);
        end else if (i_cfg_we) begin
            case (cmpi_pkg::t_cfg_reg'(i_cfg_idx))
                cmpi_pkg::CFG_ENTRY_COUNT: begin
                    r_count <= n_count;
                    r_last  <= IDX_W'(n_count - CNT_W'(1));
                end
                cmpi_pkg::CFG_RESOLUTION: begin
                    r_res <= (cfg_res == '0) ? cmpi_pkg::RES_W'(1) : cfg_res;
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves together; it halts only while the skid register holds a word.
    assign adv        = !r_skid_valid;
    assign i_in.ready = adv;
    assign accept     = i_in.valid && adv;
    assign in_word    = i_in.payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_tag.op          <= in_word.op;
            r_s0_tag.entry_index <= in_word.entry_index;
            r_s0_tag.color       <= {in_word.blue_in, in_word.green_in, in_word.red_in};
            r_s0_pos             <= POS_W'(in_word.palette_index) * POS_W'(r_count);
        end
    end

    assign c_valid[0] = r_s0_valid;
    assign c_tag[0]   = r_s0_tag;
    assign c_rem[0]   = '0;
    assign c_work[0]  = {r_s0_pos, {cmpi_pkg::FRAC_W{1'b0}}};

    for (genvar k = 0; k < QW; k++) begin : g_cell
        cmpi_div_cell #(
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_res   (r_res),
            .i_valid (c_valid[k]),
            .i_tag   (c_tag[k]),
            .i_rem   (c_rem[k]),
            .i_work  (c_work[k]),
            .o_valid (c_valid[k+1]),
            .o_tag   (c_tag[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_work  (c_work[k+1])
        );
    end

    cmpi_lookup #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .QW          (QW)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (c_valid[QW]),
        .i_tag   (c_tag[QW]),
        .i_quot  (c_work[QW]),
        .i_last  (r_last),
        .o_valid (lk_valid),
        .o_word  (lk_word)
    );

    assign push     = adv && lk_valid;
    assign fire_out = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (fire_out) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !fire_out) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (fire_out) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (fire_out) begin
                r_out_word <= r_skid_word;
            end
        end else if (push) begin
            if (r_out_valid && !fire_out) begin
                r_skid_word <= lk_word;
            end else begin
                r_out_word <= lk_word;
            end
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.payload.palette_word = r_out_word;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a word while the output register is empty");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> r_out_valid)
        else $error("a palette word leaving the lookup stage was not captured");

    a_cfg_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res != '0) && (r_count != '0) && (32'(r_last) + 32'd1 == 32'(r_count)))
        else $error("effective configuration out of range");

    a_stall_holds_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(c_valid[QW]) && $stable(c_work[QW]))
        else $error("divider chain moved while the output side was stalled");
`endif

endmodule

/* bench/tb_colormap_palette_interpolator.sv */
module tb_colormap_palette_interpolator;

    localparam int SETTLE_CYCLES = 64;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SQUEEZE_LEN   = 400;
    localparam int PHASE_WORDS   = 190;

    typedef enum {STEP_WORD, STEP_REG} t_step_kind;

    typedef struct {
        t_step_kind          kind;
        cmpi_pkg::t_cfg_reg  sel;
        logic [16:0]         val;
        cmpi_pkg::t_in       w;
        bit                  typed;
        logic [31:0]         word;
    } t_step;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [cmpi_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [cmpi_pkg::CFG_DATA_W-1:0] cfg_data;

    cmpi_stream_if #(.T(cmpi_pkg::t_in))  in_words ();
    cmpi_stream_if #(.T(cmpi_pkg::t_out)) out_words ();

    colormap_palette_interpolator DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_words),
        .o_out      (out_words)
    );

    // Mirror of the block's state as seen from the ports.
    logic [23:0] colour_map [256];
    bit          written    [256];
    logic [8:0]  count_cfg = 9'd1;
    logic [16:0] res_cfg   = 17'd256;

    logic [31:0] palette_due [$];
    int unsigned mismatches = 0;

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int unsigned live_count();
        if (count_cfg == 9'd0) return 1;
        if (count_cfg > 9'd256) return 256;
        return 32'(count_cfg);
    endfunction

    function automatic longint unsigned live_res();
        return (res_cfg == 17'd0) ? 64'd1 : 64'(res_cfg);
    endfunction

    // Splits a palette position into the two neighbouring entries and the Q0.16 ratio.
    function automatic void locate(input logic [15:0] pidx, output logic [7:0] lower,
                                   output logic [7:0] upper, output logic [15:0] frac);
        longint unsigned cnt;
        longint unsigned res;
        longint unsigned pos;
        longint unsigned rem;
        longint unsigned lo_pos;
        longint unsigned up_pos;
        cnt    = 64'(live_count());
        res    = live_res();
        pos    = 64'(pidx) * cnt;
        lo_pos = pos / res;
        rem    = pos % res;
        frac   = 16'((rem << 16) / res);
        up_pos = (rem != 0) ? lo_pos + 1 : lo_pos;
        if (lo_pos > cnt - 1) lo_pos = cnt - 1;
        if (up_pos > cnt - 1) up_pos = cnt - 1;
        lower = 8'(lo_pos);
        upper = 8'(up_pos);
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] lo, input logic [7:0] up,
                                         input logic [15:0] frac);
        longint unsigned acc;
        acc = 64'(lo) * (64'd65536 - 64'(frac)) + 64'(up) * 64'(frac);
        return acc[23:16];
    endfunction

    function automatic logic [31:0] palette_of(input logic [15:0] pidx);
        logic [7:0]  lower;
        logic [7:0]  upper;
        logic [15:0] frac;
        logic [23:0] lo_c;
        logic [23:0] up_c;
        locate(pidx, lower, upper, frac);
        lo_c = colour_map[lower];
        up_c = colour_map[upper];
        return {cmpi_pkg::ALPHA_OPAQUE, blend(lo_c[23:16], up_c[23:16], frac),
                blend(lo_c[15:8], up_c[15:8], frac), blend(lo_c[7:0], up_c[7:0], frac)};
    endfunction

    function automatic t_step put_entry(input logic [7:0] idx, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
        t_step s;
        s.kind              = STEP_WORD;
        s.sel               = cmpi_pkg::CFG_ENTRY_COUNT;
        s.val               = '0;
        s.w.op              = cmpi_pkg::OP_WRITE_ENTRY;
        s.w.entry_index     = idx;
        s.w.red_in          = r;
        s.w.green_in        = g;
        s.w.blue_in         = b;
        s.w.palette_index   = 16'($urandom);
        s.typed             = 1'b0;
        s.word              = '0;
        return s;
    endfunction

    function automatic t_step ask(input logic [15:0] pidx, input bit typed,
                                  input logic [31:0] word);
        t_step s;
        s.kind              = STEP_WORD;
        s.sel               = cmpi_pkg::CFG_ENTRY_COUNT;
        s.val               = '0;
        s.w.op              = cmpi_pkg::OP_PALETTE;
        s.w.entry_index     = 8'($urandom);
        s.w.red_in          = 8'($urandom);
        s.w.green_in        = 8'($urandom);
        s.w.blue_in         = 8'($urandom);
        s.w.palette_index   = pidx;
        s.typed             = typed;
        s.word              = word;
        return s;
    endfunction

    function automatic t_step set_reg(input cmpi_pkg::t_cfg_reg sel, input logic [16:0] val);
        t_step s;
        s.kind  = STEP_REG;
        s.sel   = sel;
        s.val   = val;
        s.w     = '0;
        s.typed = 1'b0;
        s.word  = '0;
        return s;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // A request that would touch an entry never written becomes a write of that entry.
    function automatic cmpi_pkg::t_in next_word();
        cmpi_pkg::t_in   w;
        logic [7:0]      lower;
        logic [7:0]      upper;
        logic [15:0]     frac;
        int unsigned     last;
        longint unsigned span;
        w.entry_index   = 8'($urandom);
        w.red_in        = 8'($urandom);
        w.green_in      = 8'($urandom);
        w.blue_in       = 8'($urandom);
        w.palette_index = 16'($urandom);
        last            = live_count() - 1;
        if ($urandom_range(0, 99) < 35) begin
            w.op = cmpi_pkg::OP_WRITE_ENTRY;
            if ($urandom_range(0, 9) < 6) w.entry_index = 8'($urandom_range(0, last));
        end else begin
            w.op = cmpi_pkg::OP_PALETTE;
            span = (live_res() > 64'd65536) ? 64'd65536 : live_res();
            if ($urandom_range(0, 9) < 8)
                w.palette_index = 16'($urandom_range(0, 32'(span - 1)));
            locate(w.palette_index, lower, upper, frac);
            if (!written[lower] || !written[upper]) begin
                w.op          = cmpi_pkg::OP_WRITE_ENTRY;
                w.entry_index = written[lower] ? upper : lower;
            end
        end
        return w;
    endfunction

    task automatic send_word(input cmpi_pkg::t_in w, input bit typed,
                             input logic [31:0] typed_word, input int gap);
        if (gap > 0) begin
            in_words.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_words.valid   <= 1'b1;
        in_words.payload <= w;
        do @(posedge clk); while (!in_words.ready);
        if (w.op == cmpi_pkg::OP_WRITE_ENTRY) begin
            colour_map[w.entry_index] = {w.blue_in, w.green_in, w.red_in};
            written[w.entry_index]    = 1'b1;
        end else begin
            palette_due.push_back(typed ? typed_word : palette_of(w.palette_index));
        end
    endtask

    // Registers change only once the pipeline has emptied, including trailing entry writes.
    task automatic write_reg(input cmpi_pkg::t_cfg_reg sel, input logic [16:0] val);
        in_words.valid <= 1'b0;
        while (palette_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= sel;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == cmpi_pkg::CFG_ENTRY_COUNT) count_cfg = val[8:0];
        else res_cfg = val;
    endtask

    initial begin : stimulus
        t_step       script [$];
        int unsigned n_count;
        logic [16:0] n_res;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= cmpi_pkg::CFG_ENTRY_COUNT;
        cfg_data         <= '0;
        in_words.valid   <= 1'b0;
        in_words.payload <= '0;
        script = '{
            put_entry(8'd0, 8'h12, 8'h34, 8'h56),
            ask(16'd0, 1'b1, 32'hFF563412),
            ask(16'hFFFF, 1'b1, 32'hFF563412),
            put_entry(8'd255, 8'hFF, 8'hFF, 8'hFF),
            put_entry(8'd0, 8'h00, 8'h00, 8'h00),
            put_entry(8'd1, 8'hFF, 8'hFF, 8'hFF),
            set_reg(cmpi_pkg::CFG_ENTRY_COUNT, 17'd0),
            ask(16'd200, 1'b1, 32'hFF000000),
            set_reg(cmpi_pkg::CFG_ENTRY_COUNT, 17'd2),
            set_reg(cmpi_pkg::CFG_RESOLUTION, 17'd2),
            ask(16'd0, 1'b1, 32'hFF000000),
            ask(16'd1, 1'b1, 32'hFFFFFFFF),
            ask(16'd2, 1'b1, 32'hFFFFFFFF),
            set_reg(cmpi_pkg::CFG_RESOLUTION, 17'd4),
            ask(16'd1, 1'b0, '0),
            ask(16'd3, 1'b0, '0),
            set_reg(cmpi_pkg::CFG_RESOLUTION, 17'd0),
            ask(16'd0, 1'b1, 32'hFF000000),
            ask(16'd1, 1'b1, 32'hFFFFFFFF),
            set_reg(cmpi_pkg::CFG_ENTRY_COUNT, 17'd511),
            set_reg(cmpi_pkg::CFG_RESOLUTION, 17'h10000),
            ask(16'hFFFF, 1'b1, 32'hFFFFFFFF),
            ask(16'd0, 1'b1, 32'hFF000000),
            ask(16'd128, 1'b0, '0),
            put_entry(8'd1, 8'h80, 8'h40, 8'h20),
            ask(16'd256, 1'b1, 32'hFF204080)
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].kind == STEP_REG) begin
                write_reg(script[i].sel, script[i].val);
            end else begin
                send_word(script[i].w, script[i].typed, script[i].word, pick_gap());
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    n_count = 256;
                    n_res   = 17'h10000;
                end
                1: begin
                    n_count = 256;
                    n_res   = 17'd1;
                end
                2: begin
                    n_count = 1;
                    n_res   = 17'd1;
                end
                3: begin
                    n_count = $urandom_range(257, 511);
                    n_res   = 17'($urandom_range(1, 65535));
                end
                4: begin
                    n_count = 2;
                    n_res   = 17'd3;
                end
                5: begin
                    n_count = $urandom_range(0, 511);
                    n_res   = 17'($urandom_range(0, 131071));
                end
                6: begin
                    n_count = $urandom_range(1, 256);
                    n_res   = 17'($urandom_range(1, 1024));
                end
                default: begin
                    n_count = $urandom_range(1, 256);
                    n_res   = 17'($urandom_range(1, 65536));
                end
            endcase
            write_reg(cmpi_pkg::CFG_ENTRY_COUNT, 17'(n_count));
            write_reg(cmpi_pkg::CFG_RESOLUTION, n_res);
            // Every third run of fifty words goes without sender gaps.
            for (int n = 0; n < PHASE_WORDS + ((ph == 0) ? 150 : 0); n++) begin
                send_word(next_word(), 1'b0, '0, (((n / 50) % 3) == 0) ? 0 : pick_gap());
            end
        end

        in_words.valid <= 1'b0;
        while (palette_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : receiver
        int unsigned cyc;
        int unsigned stall_left;
        int unsigned words_checked;
        bit          squeezed;
        logic [31:0] want;
        cyc           = 0;
        stall_left    = 0;
        words_checked = 0;
        squeezed      = 1'b0;
        out_words.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (out_words.valid && out_words.ready) begin
                if (palette_due.size() == 0) begin
                    $display("%0t: unexpected palette word %h", $time,
                             out_words.payload.palette_word);
                    mismatches++;
                end else begin
                    want = palette_due.pop_front();
                    if (out_words.payload.palette_word !== want) begin
                        $display("%0t: palette word mismatch, expected %h, got %h", $time,
                                 want, out_words.payload.palette_word);
                        mismatches++;
                    end
                end
                words_checked++;
            end
            cyc++;
            // One long hold-off while the sender keeps offering, so that the input backs up.
            if (!squeezed && words_checked >= 300 && in_words.valid) begin
                squeezed   = 1'b1;
                stall_left = SQUEEZE_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_words.ready <= 1'b0;
            end else if ((cyc % 600) < 150 || $urandom_range(0, 99) < 75) begin
                out_words.ready <= 1'b1;
            end else begin
                out_words.ready <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(9, 39);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_words.valid && in_words.ready) || (out_words.valid && out_words.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule
